FILE: sv/rqcd_pkg.sv
// shared types, constants and the rounding/saturation helper for the cell derotator
// no dependencies; every other file imports this package
package rqcd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ROT_W        = 16;
  localparam int CFG_LEN_W    = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FRAC_W       = 14;
  localparam int PROD_W       = SAMPLE_W + ROT_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int Q_W          = SUM_W + 1 - FRAC_W;
  localparam int CELL_MAX_DEF = 64;
  localparam int DESC_DEPTH   = 2;
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_W    = 2;
  localparam int OUT_CNT_W    = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LEN = 2'd2;

  localparam logic signed [ROT_W-1:0]  ROT_COS_RST  = 16'sd16352;
  localparam logic signed [ROT_W-1:0]  ROT_SIN_RST  = -16'sd1022;
  localparam logic [CFG_LEN_W-1:0]     CELL_LEN_RST = 7'd64;

  localparam logic signed [SUM_W:0]   RND_HALF = (SUM_W + 1)'(2 ** (FRAC_W - 1));
  localparam logic signed [Q_W-1:0]   SAT_HI   = Q_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [Q_W-1:0]   SAT_LO   = Q_W'(-(2 ** (SAMPLE_W - 1)));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_real;
    logic signed [SAMPLE_W-1:0] result_imag;
    logic                       cell_end;
  } out_item_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] rot_cos;
    logic signed [ROT_W-1:0] rot_sin;
    logic [CFG_LEN_W-1:0]    cell_length;
  } cfg_t;

  // one completed cell waiting for readout
  typedef struct packed {
    logic                 bank;
    logic [CFG_LEN_W-1:0] len;
  } desc_t;

  // readout of a bank has finished
  typedef struct packed {
    logic vld;
    logic bank;
  } done_t;

  // add half, floor shift, clamp to the sample range
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] t;
    logic signed [Q_W-1:0] q;
    t = (SUM_W + 1)'(s) + RND_HALF;
    q = t[SUM_W:FRAC_W];
    if (q > SAT_HI) begin
      q = SAT_HI;
    end else if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: sv/rqcd_front.sv
// input side: takes samples, writes them into the two cell banks, hands
// completed cells to the readout queue; depends on rqcd_pkg
module rqcd_front #(
  parameter int CELL_MAX = rqcd_pkg::CELL_MAX_DEF,
  localparam int ADDR_W  = $clog2(CELL_MAX),
  localparam int LEN_W   = $clog2(CELL_MAX + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rqcd_pkg::cfg_t     cfg,
  input  logic               push,
  output logic               full,
  input  rqcd_pkg::in_item_t in_data,
  output logic               mem_we,
  output logic [ADDR_W:0]    mem_waddr,
  output rqcd_pkg::in_item_t mem_wdata,
  output logic               desc_push,
  output rqcd_pkg::desc_t    desc_data,
  input  logic               desc_full,
  input  rqcd_pkg::done_t    done
);
  import rqcd_pkg::*;

  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              bank_r, bank_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] wr_idx;
  logic [LEN_W-1:0]  fill_inc;
  logic              accept;
  logic              cell_done;

  always_comb begin
    priority if (cfg.cell_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.cell_length > CFG_LEN_W'(CELL_MAX)) begin
      len_eff = LEN_W'(CELL_MAX);
    end else begin
      len_eff = LEN_W'(cfg.cell_length);
    end
  end

  // a partial cell no shorter than the current length restarts at slot zero
  assign wr_idx    = (fill_r >= len_eff) ? '0 : fill_r[ADDR_W-1:0];
  assign fill_inc  = LEN_W'(wr_idx) + LEN_W'(1);
  assign cell_done = (fill_inc == len_eff);

  assign full   = busy_r[bank_r] || desc_full;
  assign accept = push && !full;

  assign mem_we    = accept;
  assign mem_waddr = {bank_r, wr_idx};
  assign mem_wdata = in_data;

  assign desc_push      = accept && cell_done;
  assign desc_data.bank = bank_r;
  assign desc_data.len  = CFG_LEN_W'(len_eff);

  always_comb begin
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    if (done.vld) begin
      busy_nxt[done.bank] = 1'b0;
    end
    if (accept) begin
      if (cell_done) begin
        fill_nxt         = '0;
        bank_nxt         = ~bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

FILE: sv/rqcd_desc_fifo.sv
// two-entry queue of completed-cell descriptors between front and back
// depends on rqcd_pkg
module rqcd_desc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rqcd_pkg::desc_t din,
  output logic            full,
  input  logic            pop,
  output rqcd_pkg::desc_t dout,
  output logic            empty
);
  import rqcd_pkg::*;

  desc_t      ent_r [DESC_DEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'(DESC_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/rqcd_back.sv
// readout side: cell bank memories, address sequencer and the complex
// rotate/round/saturate pipeline; depends on rqcd_pkg
module rqcd_back #(
  parameter int CELL_MAX = rqcd_pkg::CELL_MAX_DEF,
  localparam int ADDR_W  = $clog2(CELL_MAX),
  localparam int LEN_W   = $clog2(CELL_MAX + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rqcd_pkg::cfg_t                    cfg,
  input  logic                              mem_we,
  input  logic [ADDR_W:0]                   mem_waddr,
  input  rqcd_pkg::in_item_t                mem_wdata,
  input  logic                              desc_empty,
  input  rqcd_pkg::desc_t                   desc_data,
  output logic                              desc_pop,
  output rqcd_pkg::done_t                   done,
  input  logic [rqcd_pkg::OUT_CNT_W-1:0]    out_cnt,
  output logic                              out_push,
  output rqcd_pkg::out_item_t               out_data
);
  import rqcd_pkg::*;

  localparam int MEM_D = 2 ** (ADDR_W + 1);

  logic signed [SAMPLE_W-1:0] re_mem [MEM_D];
  logic signed [SAMPLE_W-1:0] im_mem [MEM_D];

  logic              active_r, active_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic              bank_r, bank_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic              cur_bank;
  logic [LEN_W-1:0]  cur_len;
  logic [ADDR_W-1:0] cur_j;
  logic [ADDR_W-1:0] prev_j;
  logic              cur_last;
  logic              issue;
  logic [OUT_CNT_W:0] committed;

  logic                       s1_vld_r, s1_last_r;
  logic signed [SAMPLE_W-1:0] rd_re_r, rd_im_r;
  logic                       s2_vld_r, s2_last_r;
  logic signed [PROD_W-1:0]   p_rc_r, p_is_r, p_rs_r, p_ic_r;

  // start a cell straight from the queue head so cells run back to back
  assign cur_bank = active_r ? bank_r : desc_data.bank;
  assign cur_len  = active_r ? len_r : LEN_W'(desc_data.len);
  assign cur_j    = active_r ? j_r : '0;
  assign prev_j   = (cur_j == '0) ? ADDR_W'(cur_len - LEN_W'(1)) : cur_j - ADDR_W'(1);
  assign cur_last = (LEN_W'(cur_j) == cur_len - LEN_W'(1));

  // results in flight plus those queued must leave room in the output queue
  assign committed = (OUT_CNT_W + 1)'(out_cnt) + (OUT_CNT_W + 1)'(s1_vld_r)
                   + (OUT_CNT_W + 1)'(s2_vld_r);
  assign issue     = (active_r || !desc_empty) && (committed < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign desc_pop  = issue && !active_r;
  assign done.vld  = issue && cur_last;
  assign done.bank = cur_bank;

  always_comb begin
    active_nxt = active_r;
    j_nxt      = j_r;
    bank_nxt   = bank_r;
    len_nxt    = len_r;
    if (issue) begin
      active_nxt = !cur_last;
      j_nxt      = cur_j + ADDR_W'(1);
      bank_nxt   = cur_bank;
      len_nxt    = cur_len;
    end
  end

  // output j pairs real of sample j-1 (the cell's last sample for j = 0) with imag of sample j
  always_ff @(posedge clk) begin
    if (mem_we) begin
      re_mem[mem_waddr] <= mem_wdata.sample_real;
      im_mem[mem_waddr] <= mem_wdata.sample_imag;
    end
    rd_re_r <= re_mem[{cur_bank, prev_j}];
    rd_im_r <= im_mem[{cur_bank, cur_j}];
  end

  always_ff @(posedge clk) begin
    p_rc_r    <= rd_re_r * cfg.rot_cos;
    p_is_r    <= rd_im_r * cfg.rot_sin;
    p_rs_r    <= rd_re_r * cfg.rot_sin;
    p_ic_r    <= rd_im_r * cfg.rot_cos;
    s1_last_r <= cur_last;
    s2_last_r <= s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      j_r      <= '0;
      bank_r   <= 1'b0;
      len_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      j_r      <= j_nxt;
      bank_r   <= bank_nxt;
      len_r    <= len_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  assign out_push             = s2_vld_r;
  assign out_data.result_real = round_sat(SUM_W'(p_rc_r) - SUM_W'(p_is_r));
  assign out_data.result_imag = round_sat(SUM_W'(p_rs_r) + SUM_W'(p_ic_r));
  assign out_data.cell_end    = s2_last_r;

endmodule

FILE: sv/rqcd_out_fifo.sv
// small result queue that decouples the pipeline from the consumer
// depends on rqcd_pkg
module rqcd_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  rqcd_pkg::out_item_t            din,
  input  logic                           pop,
  output rqcd_pkg::out_item_t            dout,
  output logic                           empty,
  output logic [rqcd_pkg::OUT_CNT_W-1:0] cnt
);
  import rqcd_pkg::*;

  out_item_t            ent_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wp_r, wp_nxt;
  logic [OUT_PTR_W-1:0] rp_r, rp_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign cnt     = cnt_r;
  assign dout    = ent_r[rp_r];
  assign do_push = push && (cnt_r != OUT_CNT_W'(OUT_DEPTH));
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + OUT_PTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + OUT_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + OUT_CNT_W'(do_push) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/rotated_qam_cell_derotator_top.sv
// top level of the rotated-constellation cell derotator: config registers and
// the front, descriptor queue, back and result queue; depends on rqcd_pkg
//
// Usage:
//   Samples come in on a queue-style port: a beat is taken when push is high
//   and full is low. Results leave on a queue-style port: the oldest result is
//   on out_data while empty is low and is taken when pop is high.
//   Registers (rot_cos, rot_sin, cell_length) are written through cfg_we /
//   cfg_idx / cfg_wdata while the block is idle; index 3 is ignored.
//   One sample is taken per cycle while full is low. Nothing comes out until
//   a cell's last sample arrives; the cell then streams out at one result per
//   cycle while the result queue has room, each result passing through memory
//   read, multiply, then round/saturate into the result queue.
//   Two cell banks are used in turn, so the next cell fills while the last
//   one is read out; full rises only when both banks hold cells waiting.
//   If the receiver stalls, the four-entry result queue fills, readout stops,
//   and input backs up through full. Nothing is dropped.
//   Reset restores register defaults and empties every queue and bank; the
//   sample memories themselves are not cleared.
module rotated_qam_cell_derotator_top #(
  parameter int CELL_MAX = rqcd_pkg::CELL_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  rqcd_pkg::in_item_t              in_data,
  output logic                            empty,
  input  logic                            pop,
  output rqcd_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rqcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rqcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rqcd_pkg::*;

  localparam int ADDR_W = $clog2(CELL_MAX);

  cfg_t cfg_r, cfg_nxt;

  logic               mem_we;
  logic [ADDR_W:0]    mem_waddr;
  in_item_t           mem_wdata;
  logic               desc_push, desc_pop, desc_full, desc_empty;
  desc_t              desc_in, desc_out;
  done_t              done;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic               res_push;
  out_item_t          res_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROT_COS:  cfg_nxt.rot_cos     = cfg_wdata;
        REG_ROT_SIN:  cfg_nxt.rot_sin     = cfg_wdata;
        REG_CELL_LEN: cfg_nxt.cell_length = cfg_wdata[CFG_LEN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_cos     <= ROT_COS_RST;
      cfg_r.rot_sin     <= ROT_SIN_RST;
      cfg_r.cell_length <= CELL_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rqcd_front #(.CELL_MAX(CELL_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .desc_push (desc_push),
    .desc_data (desc_in),
    .desc_full (desc_full),
    .done      (done)
  );

  rqcd_desc_fifo u_desc_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .din   (desc_in),
    .full  (desc_full),
    .pop   (desc_pop),
    .dout  (desc_out),
    .empty (desc_empty)
  );

  rqcd_back #(.CELL_MAX(CELL_MAX)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .desc_empty (desc_empty),
    .desc_data  (desc_out),
    .desc_pop   (desc_pop),
    .done       (done),
    .out_cnt    (out_cnt),
    .out_push   (res_push),
    .out_data   (res_data)
  );

  rqcd_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty),
    .cnt   (out_cnt)
  );

endmodule
